[rtl/core/prf_pkg.sv]
package prf_pkg;

  localparam int SCREEN_WIDTH   = 320;
  localparam int SCREEN_HEIGHT  = 200;
  localparam int GROUPS_PER_ROW = (SCREEN_WIDTH + 15) / 16;
  localparam int STORE_DEPTH    = GROUPS_PER_ROW * SCREEN_HEIGHT;

  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int GROUP_W = (GROUPS_PER_ROW > 1) ? $clog2(GROUPS_PER_ROW) : 1;
  localparam int ENTRY_W = 64;
  localparam int WORD_W  = 16;

  localparam logic [10:0] SW_L = 11'(SCREEN_WIDTH);
  localparam logic [10:0] SH_L = 11'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(GROUPS_PER_ROW);

  localparam logic       OP_FILL = 1'b0;
  localparam logic       OP_READ = 1'b1;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // controls for one group merge
  typedef struct packed {
    logic       first;
    logic       last;
    logic [3:0] xl;
    logic [3:0] xr;
    logic [3:0] colour;
  } mask_ctl_t;

endpackage

[rtl/core/prf_store.sv]
module prf_store
  import prf_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  addr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/prf_merge.sv]
module prf_merge
  import prf_pkg::*;
(
  input  mask_ctl_t          ctl_i,
  input  logic [ENTRY_W-1:0] old_i,
  output logic [ENTRY_W-1:0] new_o
);

  logic [WORD_W-1:0] mask;

  always_comb begin
    mask = 16'hFFFF;
    if (ctl_i.first) begin
      mask = mask & (16'hFFFF >> ctl_i.xl);
    end
    if (ctl_i.last) begin
      mask = mask & (16'hFFFF << (4'd15 - ctl_i.xr));
    end
  end

  for (genvar p = 0; p < 4; p++) begin : g_plane
    assign new_o[p*WORD_W +: WORD_W] = ctl_i.colour[p]
        ? (old_i[p*WORD_W +: WORD_W] | mask)
        : (old_i[p*WORD_W +: WORD_W] & ~mask);
  end

endmodule

[rtl/core/planar_rect_fill.sv]
// Four-bitplane frame store (320x200, 20 groups of 16 pixels a row) with
// rectangle fill and group readback. Raise start_i while busy_o is low to
// issue an item; busy_o stays high until the item is finished and exactly one
// result follows as a single-cycle done_o pulse with status and plane words.
// The receiver cannot stall, so take the result in the cycle done_o is high.
// A fill walks its clipped rectangle one group at a time with a
// read-modify-write on the single store port. After reset the store is
// zeroed one entry per cycle, with busy_o high.
module planar_rect_fill
  import prf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [9:0]  pos_x_i,
  input  logic [9:0]  pos_y_i,
  input  logic [9:0]  rect_width_i,
  input  logic [9:0]  rect_height_i,
  input  logic [3:0]  colour_index_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] plane_word0_o,
  output logic [15:0] plane_word1_o,
  output logic [15:0] plane_word2_o,
  output logic [15:0] plane_word3_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_RBACK = 3'd5;

  logic [2:0] state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  // command registers
  logic       op_q;
  logic [9:0] x_q, y_q, w_q, h_q;
  logic [3:0] col_q;

  // walk registers
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [GROUP_W-1:0] g_q, g_d, g0_q, g0_d, g1_q, g1_d;
  logic [9:0]         row_q, row_d, rowl_q, rowl_d;
  logic [3:0]         xr_q, xr_d;

  logic       done_q, done_d;
  logic [1:0] status_q, status_d;
  logic [ENTRY_W-1:0] words_q, words_d;

  logic [10:0] x_end, y_end, x_clip, y_clip;
  logic        reject_fill, reject_pos;
  logic [ADDR_W-1:0] y_base, rd_addr;

  logic               mem_en, mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata, merged;
  mask_ctl_t          mctl;

  assign x_end  = {1'b0, x_q} + {1'b0, w_q} - 11'd1;
  assign y_end  = {1'b0, y_q} + {1'b0, h_q} - 11'd1;
  assign x_clip = (x_end >= SW_L) ? (SW_L - 11'd1) : x_end;
  assign y_clip = (y_end >= SH_L) ? (SH_L - 11'd1) : y_end;
  assign reject_pos  = ({1'b0, x_q} >= SW_L) || ({1'b0, y_q} >= SH_L);
  assign reject_fill = reject_pos || (w_q == 10'd0) || (h_q == 10'd0);
  assign y_base  = ADDR_W'(32'(y_q) * GROUPS_PER_ROW);
  assign rd_addr = y_base + ADDR_W'(x_q[9:4]);

  assign mctl.first  = (g_q == g0_q);
  assign mctl.last   = (g_q == g1_q);
  assign mctl.xl     = x_q[3:0];
  assign mctl.xr     = xr_q;
  assign mctl.colour = col_q;

  prf_merge u_merge (
    .ctl_i (mctl),
    .old_i (mem_rdata),
    .new_o (merged)
  );

  prf_store u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    base_d   = base_q;
    g_d      = g_q;
    g0_d     = g0_q;
    g1_d     = g1_q;
    row_d    = row_q;
    rowl_d   = rowl_q;
    xr_d     = xr_q;
    done_d   = 1'b0;
    status_d = status_q;
    words_d  = words_q;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = base_q + ADDR_W'(g_q);
    mem_wdata = merged;
    unique case (state_q)
      S_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (op_q == OP_READ) begin
          if (reject_pos) begin
            done_d   = 1'b1;
            status_d = ST_REJECT;
            words_d  = '0;
            state_d  = S_IDLE;
          end else begin
            mem_en   = 1'b1;
            mem_addr = rd_addr;
            state_d  = S_RBACK;
          end
        end else if (reject_fill) begin
          done_d   = 1'b1;
          status_d = ST_REJECT;
          words_d  = '0;
          state_d  = S_IDLE;
        end else begin
          base_d  = y_base;
          g0_d    = GROUP_W'(x_q[9:4]);
          g_d     = GROUP_W'(x_q[9:4]);
          g1_d    = GROUP_W'(x_clip[10:4]);
          xr_d    = x_clip[3:0];
          row_d   = y_q;
          rowl_d  = y_clip[9:0];
          state_d = S_RD;
        end
      end
      S_RD: begin
        mem_en  = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        if (g_q == g1_q) begin
          if (row_q == rowl_q) begin
            done_d   = 1'b1;
            status_d = ST_DONE;
            words_d  = '0;
            state_d  = S_IDLE;
          end else begin
            row_d   = row_q + 10'd1;
            base_d  = base_q + ROW_STEP;
            g_d     = g0_q;
            state_d = S_RD;
          end
        end else begin
          g_d     = g_q + GROUP_W'(1);
          state_d = S_RD;
        end
      end
      S_RBACK: begin
        done_d   = 1'b1;
        status_d = ST_READ;
        words_d  = mem_rdata;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      op_q  <= opcode_i;
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      w_q   <= rect_width_i;
      h_q   <= rect_height_i;
      col_q <= colour_index_i;
    end
    base_q   <= base_d;
    g_q      <= g_d;
    g0_q     <= g0_d;
    g1_q     <= g1_d;
    row_q    <= row_d;
    rowl_q   <= rowl_d;
    xr_q     <= xr_d;
    status_q <= status_d;
    words_q  <= words_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign plane_word0_o = words_q[0*WORD_W +: WORD_W];
  assign plane_word1_o = words_q[1*WORD_W +: WORD_W];
  assign plane_word2_o = words_q[2*WORD_W +: WORD_W];
  assign plane_word3_o = words_q[3*WORD_W +: WORD_W];

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import prf_pkg::*;

  // slowest legal run: every item a full-screen fill plus the clearing pass
  localparam int LIMIT        = 3_000_000;
  localparam int RANDOM_ITEMS = 100;
  localparam int CALM_TAIL    = 20;

  class frame_shadow;
    typedef struct packed {
      logic [1:0]  status;
      logic [15:0] w3;
      logic [15:0] w2;
      logic [15:0] w1;
      logic [15:0] w0;
    } group_result_t;

    bit [63:0]     planes [STORE_DEPTH];
    group_result_t due_results [$];
    int            mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    function void paint_group(int unsigned idx, logic [15:0] mask, logic [3:0] colour);
      for (int p = 0; p < 4; p++) begin
        if (colour[p]) begin
          planes[idx][16*p +: 16] = planes[idx][16*p +: 16] | mask;
        end else begin
          planes[idx][16*p +: 16] = planes[idx][16*p +: 16] & ~mask;
        end
      end
    endfunction

    function logic [1:0] fill_rect(int unsigned x, int unsigned y, int unsigned w,
                                   int unsigned h, logic [3:0] colour);
      int unsigned x2;
      int unsigned g0;
      int unsigned g1;
      logic [15:0] mask;
      if (w == 0 || h == 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return ST_REJECT;
      // clip to right and bottom edges
      if (x + w > SCREEN_WIDTH) w = SCREEN_WIDTH - x;
      if (y + h > SCREEN_HEIGHT) h = SCREEN_HEIGHT - y;
      x2 = x + w - 1;
      g0 = x / 16;
      g1 = x2 / 16;
      for (int unsigned row = y; row < y + h; row++) begin
        for (int unsigned g = g0; g <= g1; g++) begin
          mask = 16'hFFFF;
          // leftmost pixel of a group is bit 15
          if (g == g0) mask = mask & (16'hFFFF >> (x % 16));
          if (g == g1) mask = mask & (16'hFFFF << (15 - x2 % 16));
          if (row * GROUPS_PER_ROW + g < STORE_DEPTH) begin
            paint_group(row * GROUPS_PER_ROW + g, mask, colour);
          end
        end
      end
      return ST_DONE;
    endfunction

    function void note_item(logic op, logic [9:0] x, logic [9:0] y, logic [9:0] w,
                            logic [9:0] h, logic [3:0] colour);
      group_result_t r;
      int unsigned   idx;
      r = '0;
      if (op == OP_FILL) begin
        r.status = fill_rect(32'(x), 32'(y), 32'(w), 32'(h), colour);
      end else if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) begin
        r.status = ST_REJECT;
      end else begin
        idx = y * GROUPS_PER_ROW + x / 16;
        r.status = ST_READ;
        if (idx < STORE_DEPTH) {r.w3, r.w2, r.w1, r.w0} = planes[idx];
      end
      due_results.push_back(r);
    endfunction

    task check_result(logic [1:0] status, logic [15:0] w0, logic [15:0] w1,
                      logic [15:0] w2, logic [15:0] w3);
      group_result_t exp_r;
      if (due_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
        return;
      end
      exp_r = due_results.pop_front();
      if (status !== exp_r.status)
        report_mismatch($sformatf("status got %0d want %0d", status, exp_r.status));
      if (w0 !== exp_r.w0)
        report_mismatch($sformatf("plane_word0 got %h want %h", w0, exp_r.w0));
      if (w1 !== exp_r.w1)
        report_mismatch($sformatf("plane_word1 got %h want %h", w1, exp_r.w1));
      if (w2 !== exp_r.w2)
        report_mismatch($sformatf("plane_word2 got %h want %h", w2, exp_r.w2));
      if (w3 !== exp_r.w3)
        report_mismatch($sformatf("plane_word3 got %h want %h", w3, exp_r.w3));
    endtask

    task check_drained();
      if (due_results.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    endtask
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic        opcode_i       = OP_FILL;
  logic [9:0]  pos_x_i        = '0;
  logic [9:0]  pos_y_i        = '0;
  logic [9:0]  rect_width_i   = '0;
  logic [9:0]  rect_height_i  = '0;
  logic [3:0]  colour_index_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] plane_word0_o;
  logic [15:0] plane_word1_o;
  logic [15:0] plane_word2_o;
  logic [15:0] plane_word3_o;

  frame_shadow shadow = new();
  int          cycle_count = 0;
  bit          idling_on = 1'b0;
  int unsigned near_x = 0;
  int unsigned near_y = 0;

  planar_rect_fill u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .colour_index_i (colour_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .plane_word0_o  (plane_word0_o),
    .plane_word1_o  (plane_word1_o),
    .plane_word2_o  (plane_word2_o),
    .plane_word3_o  (plane_word3_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      shadow.check_result(status_o, plane_word0_o, plane_word1_o, plane_word2_o,
                          plane_word3_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAIL planar_rect_fill");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge after the item is taken
  task automatic send_item(logic op, logic [9:0] x, logic [9:0] y, logic [9:0] w,
                           logic [9:0] h, logic [3:0] colour);
    opcode_i       = op;
    pos_x_i        = x;
    pos_y_i        = y;
    rect_width_i   = w;
    rect_height_i  = h;
    colour_index_i = colour;
    start_i        = 1'b1;
    @(posedge clk_i);
    while (busy_o) begin
      @(negedge clk_i);
      @(posedge clk_i);
    end
    shadow.note_item(op, x, y, w, h, colour);
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  initial begin
    int unsigned pick;
    logic [9:0]  rx;
    logic [9:0]  ry;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    idling_on = 1'b1;

    // directed: store cleared, full fill, rejects, edges, partial masks
    send_item(OP_READ, 10'd0, 10'd0, 10'd0, 10'd0, 4'h0);
    send_item(OP_FILL, 10'd0, 10'd0, 10'd1023, 10'd1023, 4'hF);
    send_item(OP_READ, 10'd319, 10'd199, 10'd1023, 10'd1023, 4'hA);
    send_item(OP_FILL, 10'd5, 10'd5, 10'd0, 10'd7, 4'h0);
    send_item(OP_FILL, 10'd5, 10'd5, 10'd7, 10'd0, 4'h0);
    send_item(OP_FILL, 10'd320, 10'd0, 10'd4, 10'd4, 4'h0);
    send_item(OP_FILL, 10'd0, 10'd200, 10'd4, 10'd4, 4'h0);
    send_item(OP_FILL, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 4'h0);
    send_item(OP_FILL, 10'd0, 10'd0, 10'd1, 10'd1, 4'h5);
    send_item(OP_READ, 10'd0, 10'd0, 10'd0, 10'd0, 4'h0);
    send_item(OP_FILL, 10'd319, 10'd199, 10'd1, 10'd1, 4'hA);
    send_item(OP_READ, 10'd319, 10'd199, 10'd0, 10'd0, 4'h0);
    send_item(OP_FILL, 10'd3, 10'd5, 10'd5, 10'd3, 4'h0);
    send_item(OP_READ, 10'd3, 10'd5, 10'd0, 10'd0, 4'h0);
    send_item(OP_FILL, 10'd13, 10'd10, 10'd40, 10'd2, 4'h6);
    send_item(OP_READ, 10'd13, 10'd10, 10'd0, 10'd0, 4'h0);
    send_item(OP_READ, 10'd32, 10'd11, 10'd0, 10'd0, 4'h0);
    send_item(OP_READ, 10'd52, 10'd10, 10'd0, 10'd0, 4'h0);
    send_item(OP_FILL, 10'd300, 10'd190, 10'd100, 10'd50, 4'h9);
    send_item(OP_READ, 10'd310, 10'd199, 10'd0, 10'd0, 4'h0);
    send_item(OP_READ, 10'd320, 10'd0, 10'd0, 10'd0, 4'h0);
    send_item(OP_READ, 10'd0, 10'd200, 10'd0, 10'd0, 4'h0);
    send_item(OP_READ, 10'd1023, 10'd1023, 10'd0, 10'd0, 4'hF);
    send_item(OP_FILL, 10'd0, 10'd0, 10'd320, 10'd200, 4'h0);
    send_item(OP_READ, 10'd160, 10'd100, 10'd0, 10'd0, 4'h0);

    // random: mostly small on-screen fills read back near where they landed
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - CALM_TAIL) idling_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        rx = 10'($urandom_range(0, SCREEN_WIDTH - 1));
        ry = 10'($urandom_range(0, SCREEN_HEIGHT - 1));
        near_x = 32'(rx);
        near_y = 32'(ry);
        send_item(OP_FILL, rx, ry, 10'($urandom_range(1, 48)), 10'($urandom_range(1, 12)),
                  4'($urandom_range(0, 15)));
      end else if (pick < 55) begin
        rx = 10'($urandom_range(0, SCREEN_WIDTH - 1));
        ry = 10'($urandom_range(0, SCREEN_HEIGHT - 1));
        near_x = 32'(rx);
        near_y = 32'(ry);
        send_item(OP_FILL, rx, ry, 10'($urandom_range(0, 1023)), 10'($urandom_range(1, 4)),
                  4'($urandom_range(0, 15)));
      end else if (pick < 58) begin
        send_item(OP_FILL, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                  4'($urandom_range(0, 15)));
      end else if (pick < 65) begin
        case ($urandom_range(0, 2))
          0: send_item(OP_FILL, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                       10'd0, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
          1: send_item(OP_FILL, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                       10'($urandom_range(0, 1023)), 10'd0, 4'($urandom_range(0, 15)));
          default: send_item(OP_FILL, 10'($urandom_range(SCREEN_WIDTH, 1023)),
                             10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                             10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
        endcase
      end else if (pick < 92) begin
        send_item(OP_READ, 10'(near_x + $urandom_range(0, 47)),
                  10'(near_y + $urandom_range(0, 11)),
                  10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                  4'($urandom_range(0, 15)));
      end else begin
        send_item(OP_READ, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                  4'($urandom_range(0, 15)));
      end
    end
    start_i = 1'b0;

    while (shadow.due_results.size() != 0) @(posedge clk_i);
    // catch any stray result
    repeat (16) @(posedge clk_i);
    shadow.check_drained();
    if (shadow.mismatches == 0) begin
      $display("PASS planar_rect_fill");
    end else begin
      $display("FAIL planar_rect_fill");
    end
    $finish;
  end

endmodule
